FILE: hdl/cia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types, codes and helpers of the checked 64-bit integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    localparam int ACTION_W  = 4;
    localparam int ERR_W     = 2;
    localparam int DIV_STEPS = DATA_W;
    localparam int MUL_DEPTH = 3;

    localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD = 4'd0,
        ACT_SUB = 4'd1,
        ACT_MUL = 4'd2,
        ACT_DIV = 4'd3,
        ACT_MOD = 4'd4,
        ACT_LT  = 4'd5,
        ACT_LE  = 4'd6,
        ACT_GT  = 4'd7,
        ACT_GE  = 4'd8,
        ACT_EQ  = 4'd9,
        ACT_NE  = 4'd10
    } t_action;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_DIV_ZERO = 2'd2
    } t_err;

    // side information that rides alongside the divider
    typedef struct packed {
        logic              valid;
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0] res;
        t_err              err;
        logic              neg_q;
        logic              neg_r;
    } t_tag;

    function automatic logic [DATA_W-1:0] negate_if(input logic [DATA_W-1:0] x,
                                                    input logic neg);
        negate_if = neg ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
        magnitude = negate_if(x, x[DATA_W-1]);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/cia_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_req_if / cia_rsp_if
// Valid/ready channels carrying ALU requests and responses.
// ----------------------------------------------------------------------------
interface cia_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;

    modport source (output valid, action, left_operand, right_operand, input ready);
    modport sink   (input valid, action, left_operand, right_operand, output ready);
endinterface

interface cia_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] value;
    logic [1:0]  error_code;

    modport source (output valid, value, error_code, input ready);
    modport sink   (input valid, value, error_code, output ready);
endinterface
`default_nettype wire

FILE: hdl/cia_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_delay
// Enabled shift line that holds a word for a fixed number of stages.
// ----------------------------------------------------------------------------
module cia_delay #(
    parameter int DEPTH = 1,
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_data,
    output logic      [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_line [DEPTH];

    // reset clears the line so that any valid flag carried inside is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_line[k] <= '0;
        end else if (i_en) begin
            r_line[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) r_line[k] <= r_line[k-1];
        end
    end

    assign o_data = r_line[DEPTH-1];
endmodule
`default_nettype wire

FILE: hdl/cia_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_mul
// Three-stage 64x64 magnitude multiplier with signed overflow check.
// ----------------------------------------------------------------------------
module cia_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [cia_pkg::DATA_W-1:0] i_ma,
    input  wire logic [cia_pkg::DATA_W-1:0] i_mb,
    input  wire logic                       i_neg,
    output logic      [cia_pkg::DATA_W-1:0] o_res,
    output logic                            o_ovf
);
    import cia_pkg::*;

    logic [DATA_W-1:0] r_ll, r_lh, r_hl, r_hh;
    logic              r_neg1, r_neg2;
    logic [DATA_W:0]   r_mid, r_lo;
    logic [DATA_W-1:0] r_hh2;
    logic [DATA_W-1:0] n_hi, n_limit;

    // stage 1: four 32x32 partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll   <= i_ma[HALF_W-1:0]      * i_mb[HALF_W-1:0];
            r_lh   <= i_ma[HALF_W-1:0]      * i_mb[DATA_W-1:HALF_W];
            r_hl   <= i_ma[DATA_W-1:HALF_W] * i_mb[HALF_W-1:0];
            r_hh   <= i_ma[DATA_W-1:HALF_W] * i_mb[DATA_W-1:HALF_W];
            r_neg1 <= i_neg;
        end
    end

    // stage 2: middle sum and low word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid  <= {1'b0, r_lh} + {1'b0, r_hl};
            r_lo   <= {1'b0, r_ll} + {1'b0, (r_lh[HALF_W-1:0] + r_hl[HALF_W-1:0]),
                                        {HALF_W{1'b0}}};
            r_hh2  <= r_hh;
            r_neg2 <= r_neg1;
        end
    end

    // stage 3: high word, range check and sign
    always_comb begin
        n_hi    = r_hh2 + {{(HALF_W-1){1'b0}}, r_mid[DATA_W:HALF_W]}
                        + {{(DATA_W-1){1'b0}}, r_lo[DATA_W]};
        n_limit = r_neg2 ? SIGN_BIT : (SIGN_BIT - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ovf <= (n_hi != '0) || (r_lo[DATA_W-1:0] > n_limit);
            o_res <= negate_if(r_lo[DATA_W-1:0], r_neg2);
        end
    end
endmodule
`default_nettype wire

FILE: hdl/cia_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module cia_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [cia_pkg::DATA_W-1:0] i_ma,
    input  wire logic [cia_pkg::DATA_W-1:0] i_mb,
    output logic      [cia_pkg::DATA_W-1:0] o_quot,
    output logic      [cia_pkg::DATA_W-1:0] o_rem
);
    import cia_pkg::*;

    logic [DATA_W-1:0] r_rem [DIV_STEPS];
    logic [DATA_W-1:0] r_q   [DIV_STEPS];
    logic [DATA_W-1:0] r_d   [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DATA_W-1:0] rem_in, q_in, d_in;
        logic [DATA_W:0]   n_trial;
        logic              n_ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = i_ma;
            assign d_in   = i_mb;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign d_in   = r_d[k-1];
        end

        always_comb begin
            n_trial = {rem_in, q_in[DATA_W-1]};
            n_ge    = n_trial >= {1'b0, d_in};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? DATA_W'(n_trial - {1'b0, d_in}) : n_trial[DATA_W-1:0];
                r_q[k]   <= {q_in[DATA_W-2:0], n_ge};
                r_d[k]   <= d_in;
            end
        end
    end

    assign o_quot = r_q[DIV_STEPS-1];
    assign o_rem  = r_rem[DIV_STEPS-1];
endmodule
`default_nettype wire

FILE: hdl/checked_int64_alu_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checked_int64_alu_top
// Pipelined checked 64-bit integer ALU: add, sub, mul, div, mod, compares.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                  Handshake
//  i_req    in   action, left_operand, right_operand      valid/ready
//  o_res    out  value, error_code                        valid/ready
//
//  Every operation takes the same path: one operand stage, 64 divider stages
//  (the restoring divider sets the depth), one output register. That is 66
//  register stages. One transfer is taken per cycle whenever the pipeline
//  advances.
//  The whole pipeline advances together; it holds while the output register
//  is full and not taken, and i_req.ready drops only then.
//  Reset (synchronous, active low) clears all valid flags.
// ----------------------------------------------------------------------------
module checked_int64_alu_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cia_req_if.sink   i_req,
    cia_rsp_if.source o_res
);
    import cia_pkg::*;

    logic              adv;
    logic [DATA_W-1:0] a, b, sum, dif;
    logic              lt, gt, eq;
    t_tag              n_tag, r_tag, tag_out;
    logic [DATA_W-1:0] r_ma, r_mb;
    logic              r_neg_q;
    logic [DATA_W-1:0] mul_res, mul_res_d, quot, rem;
    logic              mul_ovf, mul_ovf_d;
    logic [DATA_W-1:0] n_value;
    t_err              n_err;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_value;
    t_err              r_err;

    // advance everything unless the output holds an untaken result
    assign adv         = !r_out_valid || o_res.ready;
    assign i_req.ready = adv;

    // operand stage: cheap ops finish here, all exceptions but multiply overflow are flagged
    always_comb begin
        a     = i_req.left_operand;
        b     = i_req.right_operand;
        sum   = a + b;
        dif   = a - b;
        lt    = $signed(a) < $signed(b);
        gt    = $signed(a) > $signed(b);
        eq    = a == b;
        n_tag.valid  = i_req.valid;
        n_tag.action = i_req.action;
        n_tag.res    = '0;
        n_tag.err    = ERR_NONE;
        n_tag.neg_q  = a[DATA_W-1] ^ b[DATA_W-1];
        n_tag.neg_r  = a[DATA_W-1];
        case (i_req.action)
            ACT_ADD: begin
                if (a[DATA_W-1] == b[DATA_W-1] && sum[DATA_W-1] != a[DATA_W-1])
                    n_tag.err = ERR_OVERFLOW;
                else
                    n_tag.res = sum;
            end
            ACT_SUB: begin
                if (a[DATA_W-1] != b[DATA_W-1] && dif[DATA_W-1] != a[DATA_W-1])
                    n_tag.err = ERR_OVERFLOW;
                else
                    n_tag.res = dif;
            end
            ACT_DIV, ACT_MOD: begin
                // zero divisor wins over the most-negative-by-minus-one case
                if (b == '0)
                    n_tag.err = ERR_DIV_ZERO;
                else if (a == SIGN_BIT && b == ALL_ONES)
                    n_tag.err = ERR_OVERFLOW;
            end
            ACT_LT:  n_tag.res = {{(DATA_W-1){1'b0}}, lt};
            ACT_LE:  n_tag.res = {{(DATA_W-1){1'b0}}, !gt};
            ACT_GT:  n_tag.res = {{(DATA_W-1){1'b0}}, gt};
            ACT_GE:  n_tag.res = {{(DATA_W-1){1'b0}}, !lt};
            ACT_EQ:  n_tag.res = {{(DATA_W-1){1'b0}}, eq};
            ACT_NE:  n_tag.res = {{(DATA_W-1){1'b0}}, !eq};
            default: n_tag.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (adv) begin
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ma    <= magnitude(i_req.left_operand);
            r_mb    <= magnitude(i_req.right_operand);
            r_neg_q <= n_tag.neg_q;
        end
    end

    cia_mul u_mul (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_ma  (r_ma),
        .i_mb  (r_mb),
        .i_neg (r_neg_q),
        .o_res (mul_res),
        .o_ovf (mul_ovf)
    );

    // line the product up with the end of the divider
    cia_delay #(.DEPTH(DIV_STEPS - MUL_DEPTH), .WIDTH(DATA_W + 1)) u_mul_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_data  ({mul_ovf, mul_res}),
        .o_data  ({mul_ovf_d, mul_res_d})
    );

    cia_div u_div (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_ma   (r_ma),
        .i_mb   (r_mb),
        .o_quot (quot),
        .o_rem  (rem)
    );

    cia_delay #(.DEPTH(DIV_STEPS), .WIDTH($bits(t_tag))) u_tag_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_data  (r_tag),
        .o_data  (tag_out)
    );

    // final select; any error forces the value to zero
    always_comb begin
        n_value = tag_out.res;
        n_err   = tag_out.err;
        case (tag_out.action)
            ACT_MUL: begin
                n_err   = mul_ovf_d ? ERR_OVERFLOW : ERR_NONE;
                n_value = mul_ovf_d ? '0 : mul_res_d;
            end
            ACT_DIV: n_value = (tag_out.err != ERR_NONE) ? '0
                                                          : negate_if(quot, tag_out.neg_q);
            ACT_MOD: n_value = (tag_out.err != ERR_NONE) ? '0
                                                          : negate_if(rem, tag_out.neg_r);
            default: n_value = tag_out.res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tag_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_value <= n_value;
            r_err   <= n_err;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_value;
    assign o_res.error_code = r_err;
endmodule
`default_nettype wire

FILE: hdl/cia_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_checker
// Port-level checks of the ALU response channel and input ready, bound to the top level.
// ----------------------------------------------------------------------------
module cia_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_value,
    input wire logic [1:0]  i_error_code
);
    import cia_pkg::*;

    // an error always comes with a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_error_code != ERR_NONE) |-> (i_value == '0))
        else $error("error response with nonzero value");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_error_code == ERR_NONE || i_error_code == ERR_OVERFLOW ||
                         i_error_code == ERR_DIV_ZERO))
        else $error("undefined error code");

    // a held response keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_value)))
        else $error("response dropped or changed while stalled");

    // input is refused only while the output is blocked
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");
endmodule

bind checked_int64_alu_top cia_checker u_cia_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_value      (o_res.value),
    .i_error_code (o_res.error_code)
);
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checked 64-bit integer ALU: a directed table of
// corner operations followed by random traffic with random idle on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import cia_pkg::*;

    localparam int LATENCY = 66;
    localparam int N_RANDOM = 830;

    typedef struct {
        logic [3:0]  action;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic        known;      // expected result typed into the row
        logic [63:0] value;
        logic [1:0]  err;
    } t_row;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  err;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cia_req_if req_ch ();
    cia_rsp_if rsp_ch ();

    checked_int64_alu_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (rsp_ch.source)
    );

    always #10 i_clk = ~i_clk;

    t_result pending_results[$];
    int      error_count = 0;
    int      result_count = 0;
    int      item_count = 0;
    bit      no_idle = 1'b0;
    t_row    directed[$];

    localparam logic [63:0] MIN64 = SIGN_BIT;
    localparam logic [63:0] MAX64 = ~SIGN_BIT;
    localparam logic [63:0] NEG1  = ALL_ONES;

    // Compute the checked ALU result of one operation.
    function automatic t_result alu_result(logic [3:0] act, logic [63:0] a,
                                           logic [63:0] b);
        t_result     r;
        logic [63:0] ma, mb, lim;
        logic [127:0] prod;
        logic        neg;
        logic        lt_ab, lt_ba;
        r.value = '0;
        r.err = ERR_NONE;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        lt_ab = $signed(a) < $signed(b);
        lt_ba = $signed(b) < $signed(a);
        case (act)
            ACT_ADD: begin
                r.value = a + b;
                if (a[63] == b[63] && r.value[63] != a[63]) r.err = ERR_OVERFLOW;
            end
            ACT_SUB: begin
                r.value = a - b;
                if (a[63] != b[63] && r.value[63] != a[63]) r.err = ERR_OVERFLOW;
            end
            ACT_MUL: begin
                neg = a[63] ^ b[63];
                lim = neg ? SIGN_BIT : ~SIGN_BIT;
                prod = ma * mb;
                if (ma != 0 && mb != 0) begin
                    if (prod > {64'd0, lim}) r.err = ERR_OVERFLOW;
                    else r.value = neg ? -prod[63:0] : prod[63:0];
                end
            end
            ACT_DIV, ACT_MOD: begin
                if (b == 0) r.err = ERR_DIV_ZERO;
                else if (a == MIN64 && b == NEG1) r.err = ERR_OVERFLOW;
                else if (act == ACT_DIV) begin
                    r.value = (a[63] ^ b[63]) ? -(ma / mb) : ma / mb;
                end else begin
                    r.value = a[63] ? -(ma % mb) : ma % mb;
                end
            end
            ACT_LT: r.value = {63'd0, lt_ab};
            ACT_LE: r.value = {63'd0, !lt_ba};
            ACT_GT: r.value = {63'd0, lt_ba};
            ACT_GE: r.value = {63'd0, !lt_ab};
            ACT_EQ: r.value = {63'd0, (a == b)};
            ACT_NE: r.value = {63'd0, (a != b)};
            default: r.value = '0;
        endcase
        if (r.err != ERR_NONE) r.value = '0;
        return r;
    endfunction

    function automatic void add_row(logic [3:0] act, logic [63:0] a, logic [63:0] b,
                                    logic known, logic [63:0] v, logic [1:0] e);
        t_row row;
        row.action = act; row.lhs = a; row.rhs = b;
        row.known = known; row.value = v; row.err = e;
        directed = {directed, row};
    endfunction

    // Random operand biased toward the edges of the range.
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = MIN64;
            1: v = MAX64;
            2: v = NEG1;
            3: v = 64'd0;
            4: v = $urandom_range(0, 20) - 10;
            5: v = {{32{1'b0}}, $urandom()} ^ ({64{$urandom_range(0, 1) == 1}});
            6: v = {{33{1'b0}}, 31'($urandom())} - 64'h4000_0000;
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    task automatic send(logic [3:0] act, logic [63:0] a, logic [63:0] b);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.left_operand <= a;
        req_ch.right_operand <= b;
        // hold until the transfer happens at a rising edge
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results = {pending_results, alu_result(act, a, b)};
        item_count++;
        @(negedge i_clk);
    endtask

    // Sink side: random stall bursts, stop stalling late in the run.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each transfer on the result channel with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: value %h error_code %0d",
                       rsp_ch.value, rsp_ch.error_code);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                result_count++;
                if (rsp_ch.value !== want.value) begin
                    $error("value: expected %h, actual %h", want.value, rsp_ch.value);
                    error_count++;
                end
                if (rsp_ch.error_code !== want.err) begin
                    $error("error_code: expected %0d, actual %0d",
                           want.err, rsp_ch.error_code);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random traffic, then drain.
    initial begin
        t_row    row;
        t_result calc;
        logic [3:0] act;
        req_ch.valid = 1'b0;
        req_ch.action = '0;
        req_ch.left_operand = '0;
        req_ch.right_operand = '0;

        add_row(ACT_ADD, MAX64, 64'd1, 1, 0, ERR_OVERFLOW);
        add_row(ACT_ADD, MIN64, NEG1, 1, 0, ERR_OVERFLOW);
        add_row(ACT_ADD, MAX64, MIN64, 1, NEG1, ERR_NONE);
        add_row(ACT_SUB, MIN64, 64'd1, 1, 0, ERR_OVERFLOW);
        add_row(ACT_SUB, 64'd0, MIN64, 1, 0, ERR_OVERFLOW);
        add_row(ACT_SUB, NEG1, MIN64, 1, MAX64, ERR_NONE);
        add_row(ACT_MUL, MAX64, 64'd0, 1, 0, ERR_NONE);
        add_row(ACT_MUL, 64'd0, MIN64, 1, 0, ERR_NONE);
        add_row(ACT_MUL, MIN64, NEG1, 1, 0, ERR_OVERFLOW);
        add_row(ACT_MUL, MIN64, 64'd1, 1, MIN64, ERR_NONE);
        add_row(ACT_MUL, 64'h1_0000_0000, 64'h8000_0000, 0, 0, 0);
        add_row(ACT_MUL, 64'h1_0000_0000, 64'hFFFF_FFFF_8000_0000, 0, 0, 0);
        add_row(ACT_DIV, MAX64, 64'd0, 1, 0, ERR_DIV_ZERO);
        add_row(ACT_DIV, MIN64, NEG1, 1, 0, ERR_OVERFLOW);
        add_row(ACT_DIV, -64'sd7, 64'd2, 1, -64'sd3, ERR_NONE);
        add_row(ACT_MOD, MIN64, 64'd0, 1, 0, ERR_DIV_ZERO);
        add_row(ACT_MOD, MIN64, NEG1, 1, 0, ERR_OVERFLOW);
        add_row(ACT_MOD, -64'sd7, 64'd2, 1, NEG1, ERR_NONE);
        add_row(ACT_MOD, 64'd7, -64'sd2, 1, 64'd1, ERR_NONE);
        add_row(ACT_LT, MIN64, MAX64, 1, 64'd1, ERR_NONE);
        add_row(ACT_LE, MAX64, MAX64, 1, 64'd1, ERR_NONE);
        add_row(ACT_GT, MIN64, MAX64, 1, 64'd0, ERR_NONE);
        add_row(ACT_GE, NEG1, 64'd0, 1, 64'd0, ERR_NONE);
        add_row(ACT_EQ, MIN64, MIN64, 1, 64'd1, ERR_NONE);
        add_row(ACT_NE, MAX64, MIN64, 1, 64'd1, ERR_NONE);
        add_row(4'd11, MAX64, MAX64, 1, 0, ERR_NONE);
        add_row(4'd15, MIN64, NEG1, 1, 0, ERR_NONE);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            row = directed[i];
            calc = alu_result(row.action, row.lhs, row.rhs);
            // cross-check typed rows against the predictor
            if (row.known && (calc.value !== row.value || calc.err !== row.err)) begin
                $error("table row %0d: expected %h/%0d, predictor %h/%0d",
                       i, row.value, row.err, calc.value, calc.err);
                error_count++;
            end
            send(row.action, row.lhs, row.rhs);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 120) no_idle = 1'b1;
            act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                               : 4'($urandom_range(0, 10));
            send(act, pick_operand(), pick_operand());
        end
        req_ch.valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Covered %0d requests, %0d results checked, all eleven operations",
                 item_count, result_count);
        $display("plus unused codes, overflow and zero-divisor traps.");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: checked_int64_alu_top.f
hdl/cia_pkg.sv
hdl/cia_if.sv
hdl/cia_delay.sv
hdl/cia_mul.sv
hdl/cia_div.sv
hdl/checked_int64_alu_top.sv
hdl/cia_checker.sv
bench/tb_top.sv
